// ===== src/ffea_pkg.sv =====
`timescale 1ns / 1ps
package ffea_pkg;

	localparam int FREE_ENTRIES = 16;
	localparam int FILE_ENTRIES = 16;
	localparam int FREE_AW = $clog2(FREE_ENTRIES);
	localparam int FILE_AW = $clog2(FILE_ENTRIES);
	localparam int FREE_CW = $clog2(FREE_ENTRIES + 1);
	localparam int FILE_CW = $clog2(FILE_ENTRIES + 1);
	localparam int IDX_W = (FREE_CW > FILE_CW) ? FREE_CW : FILE_CW;
	localparam int PADDR_W = 2;
	localparam logic [15:0] TOTAL_RESET = 16'd1024;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_NO_SPACE = 3'd1,
		STAT_FILE_FULL = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FREE_FULL = 3'd4,
		STAT_ZERO_SIZE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic init;
		logic [15:0] total;
	} cfg_t;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] len;
	} extent_t;

	typedef struct packed {
		logic [15:0] key;
		logic [15:0] start;
		logic [15:0] len;
	} file_ent_t;

endpackage

// ===== src/ffea_if.sv =====
`timescale 1ns / 1ps
interface ffea_req_if;
	logic valid;
	logic ready;
	logic command;
	logic [15:0] file_id;
	logic [15:0] size;
	modport source(output valid, command, file_id, size, input ready);
	modport sink(input valid, command, file_id, size, output ready);
endinterface

interface ffea_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [15:0] start_block;
	logic [15:0] extent_length;
	modport source(output valid, status, start_block, extent_length, input ready);
	modport sink(input valid, status, start_block, extent_length, output ready);
endinterface

// ===== src/ffea_apb.sv =====
`timescale 1ns / 1ps
module ffea_apb (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ffea_pkg::PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output ffea_pkg::cfg_t cfg
);
	import ffea_pkg::*;

	logic [15:0] total_q;
	logic init_q;
	logic wr;

	assign wr = psel & penable & pwrite & pready & (paddr == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			init_q <= 1'b0;
		end else begin
			init_q <= wr;
			if (wr) begin
				total_q <= pwdata[15:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == '0) ? {16'd0, total_q} : 32'd0;
	assign cfg.init = init_q;
	assign cfg.total = total_q;
endmodule

// ===== src/first_fit_extent_allocator_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields                                   Handshake
// req      in   command, file_id, size                   valid/ready
// rsp      out  status, start_block, extent_length       valid/ready
// apb      in   total_blocks at byte address 0           psel/penable, pready high
// An allocate scans the extents in the free table memory and, when an extent
// empties, moves the later extents down one entry. A free scans the file
// table the same way, appends its extent to the free table, moves later files down.
// Each table memory gives one read and one write per cycle; scans are pipelined.
// Reset and a total_blocks write leave one free extent and no files, with no
// clearing pass. A word is taken while the previous result still waits.
module first_fit_extent_allocator_core (
	input logic clk,
	input logic arst_n,
	ffea_req_if.sink req,
	ffea_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ffea_pkg::PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ffea_pkg::*;

	cfg_t cfg;

	ffea_apb u_apb (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	extent_t free_mem [FREE_ENTRIES];
	file_ent_t file_mem [FILE_ENTRIES];

	state_t state_q, state_d;
	logic [FREE_CW-1:0] free_cnt_q, free_cnt_d;
	logic [FILE_CW-1:0] file_cnt_q, file_cnt_d;
	logic e0v_q, e0v_d;
	logic [IDX_W-1:0] idx_q, idx_d, idx_s1, hit_q, hit_d;
	logic pend_s1, pend_d;
	logic out_v_q, out_v_d;
	cmd_t cmd_q;
	logic [15:0] id_q, size_q, hstart_q, hstart_d, hlen_q, hlen_d;
	status_t res_st_q, res_st_d;
	logic [15:0] res_start_q, res_start_d, res_len_q, res_len_d;
	logic [2:0] out_st_q;
	logic [15:0] out_start_q, out_len_q;
	logic load_out;

	logic [15:0] total_s1;
	logic virt_s1;
	extent_t free_raw_s1, free_rd;
	file_ent_t file_rd;

	logic free_we, file_we;
	logic [FREE_AW-1:0] free_waddr;
	logic [FILE_AW-1:0] file_waddr;
	extent_t free_wdata;
	file_ent_t file_wdata;

	logic [IDX_W-1:0] cnt, wr_idx;
	logic issue, hit;
	logic [15:0] new_len;

	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_waddr] <= free_wdata;
		end
		free_raw_s1 <= free_mem[idx_q[FREE_AW-1:0]];
		virt_s1 <= (idx_q[FREE_AW-1:0] == '0) && !e0v_q;
		total_s1 <= cfg.total;
	end

	always_ff @(posedge clk) begin
		if (file_we) begin
			file_mem[file_waddr] <= file_wdata;
		end
		file_rd <= file_mem[idx_q[FILE_AW-1:0]];
	end

	assign free_rd = virt_s1 ? '{start: 16'd0, len: total_s1} : free_raw_s1;
	assign new_len = hlen_q - size_q;
	assign wr_idx = idx_s1 - IDX_W'(1);

	always_comb begin
		cnt = (cmd_q == CMD_ALLOC) ? IDX_W'(free_cnt_q) : IDX_W'(file_cnt_q);
		issue = idx_q < cnt;
		hit = (cmd_q == CMD_ALLOC) ? (free_rd.len >= size_q) : (file_rd.key == id_q);
	end

	always_comb begin
		state_d = state_q;
		free_cnt_d = free_cnt_q;
		file_cnt_d = file_cnt_q;
		e0v_d = e0v_q;
		idx_d = idx_q;
		pend_d = 1'b0;
		hit_d = hit_q;
		hstart_d = hstart_q;
		hlen_d = hlen_q;
		res_st_d = res_st_q;
		res_start_d = res_start_q;
		res_len_d = res_len_q;
		free_we = 1'b0;
		file_we = 1'b0;
		free_waddr = wr_idx[FREE_AW-1:0];
		file_waddr = wr_idx[FILE_AW-1:0];
		free_wdata = free_rd;
		file_wdata = file_rd;
		load_out = 1'b0;
		out_v_d = out_v_q && !rsp.ready;
		case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (req.valid) begin
					if (req.command == CMD_ALLOC && req.size == 16'd0) begin
						res_st_d = STAT_ZERO_SIZE;
						res_start_d = '0;
						res_len_d = '0;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (issue) begin
					idx_d = idx_q + IDX_W'(1);
					pend_d = 1'b1;
				end
				if (pend_s1 && hit) begin
					pend_d = 1'b0;
					hit_d = idx_s1;
					hstart_d = (cmd_q == CMD_ALLOC) ? free_rd.start : file_rd.start;
					hlen_d = (cmd_q == CMD_ALLOC) ? free_rd.len : file_rd.len;
					state_d = ST_UPDATE;
				end else if (!pend_s1 && !issue) begin
					res_st_d = (cmd_q == CMD_ALLOC) ? STAT_NO_SPACE : STAT_NOT_FOUND;
					res_start_d = '0;
					res_len_d = '0;
					state_d = ST_FINISH;
				end
			end
			ST_UPDATE: begin
				res_start_d = '0;
				res_len_d = '0;
				idx_d = hit_q + IDX_W'(1);
				state_d = ST_FINISH;
				if (cmd_q == CMD_ALLOC) begin
					if (file_cnt_q == FILE_CW'(FILE_ENTRIES)) begin
						res_st_d = STAT_FILE_FULL;
					end else begin
						res_st_d = STAT_OK;
						res_start_d = hstart_q;
						res_len_d = size_q;
						file_we = 1'b1;
						file_waddr = file_cnt_q[FILE_AW-1:0];
						file_wdata = '{key: id_q, start: hstart_q, len: size_q};
						file_cnt_d = file_cnt_q + FILE_CW'(1);
						if (new_len != 16'd0) begin
							free_we = 1'b1;
							free_waddr = hit_q[FREE_AW-1:0];
							free_wdata = '{start: hstart_q + size_q, len: new_len};
							if (hit_q == '0) begin
								e0v_d = 1'b1;
							end
						end else begin
							state_d = ST_SHIFT;
						end
					end
				end else begin
					if (free_cnt_q == FREE_CW'(FREE_ENTRIES)) begin
						res_st_d = STAT_FREE_FULL;
					end else begin
						res_st_d = STAT_OK;
						res_start_d = hstart_q;
						res_len_d = hlen_q;
						free_we = 1'b1;
						free_waddr = free_cnt_q[FREE_AW-1:0];
						free_wdata = '{start: hstart_q, len: hlen_q};
						free_cnt_d = free_cnt_q + FREE_CW'(1);
						if (free_cnt_q == '0) begin
							e0v_d = 1'b1;
						end
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (issue) begin
					idx_d = idx_q + IDX_W'(1);
					pend_d = 1'b1;
				end
				if (pend_s1) begin
					if (cmd_q == CMD_ALLOC) begin
						free_we = 1'b1;
						if (wr_idx == '0) begin
							e0v_d = 1'b1;
						end
					end else begin
						file_we = 1'b1;
					end
				end else if (!issue) begin
					if (cmd_q == CMD_ALLOC) begin
						free_cnt_d = free_cnt_q - FREE_CW'(1);
					end else begin
						file_cnt_d = file_cnt_q - FILE_CW'(1);
					end
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_v_q || rsp.ready) begin
					load_out = 1'b1;
					out_v_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			free_cnt_q <= FREE_CW'(1);
			file_cnt_q <= '0;
			e0v_q <= 1'b0;
			idx_q <= '0;
			pend_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			pend_s1 <= pend_d;
			out_v_q <= out_v_d;
			if (cfg.init) begin
				free_cnt_q <= FREE_CW'(1);
				file_cnt_q <= '0;
				e0v_q <= 1'b0;
			end else begin
				free_cnt_q <= free_cnt_d;
				file_cnt_q <= file_cnt_d;
				e0v_q <= e0v_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		hit_q <= hit_d;
		hstart_q <= hstart_d;
		hlen_q <= hlen_d;
		res_st_q <= res_st_d;
		res_start_q <= res_start_d;
		res_len_q <= res_len_d;
		if (state_q == ST_IDLE && req.valid) begin
			cmd_q <= cmd_t'(req.command);
			id_q <= req.file_id;
			size_q <= req.size;
		end
		if (load_out) begin
			out_st_q <= res_st_q;
			out_start_q <= res_start_q;
			out_len_q <= res_len_q;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.status = out_st_q;
	assign rsp.start_block = out_start_q;
	assign rsp.extent_length = out_len_q;
endmodule

// ===== src/ffea_checker.sv =====
`timescale 1ns / 1ps
module ffea_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] status,
	input logic [15:0] start_block,
	input logic [15:0] extent_length
);
	import ffea_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |-> start_block == 16'd0 && extent_length == 16'd0)
		else $error("error result carries an extent");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= STAT_ZERO_SIZE)
		else $error("undefined status code");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_OK |-> extent_length != 16'd0)
		else $error("successful result with empty extent");
endmodule

bind first_fit_extent_allocator_core ffea_checker u_ffea_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.start_block(rsp.start_block),
	.extent_length(rsp.extent_length)
);
